FILE: hw/rtl/mm3_pkg.sv
// mm3_pkg: constants, mix mode codes and controller/datapath link types
// for the murmur3 32-bit hash engine; no dependencies
`timescale 1ns / 1ps

package mm3_pkg;

  localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2 = 32'h1b873593;
  localparam logic [31:0] MM_N  = 32'he6546b64;
  localparam logic [31:0] MM_F1 = 32'h85ebca6b;
  localparam logic [31:0] MM_F2 = 32'hc2b2ae35;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_TAIL = 2'd1;
  localparam logic [1:0] MODE_FULL = 2'd2;

  localparam int unsigned REG_SEED = 0;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic acc;
    logic fin1;
    logic fin2;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_busy;
  } sts_t;

endpackage

FILE: hw/rtl/murmur3_32_hash_top.sv
// murmur3_32_hash_top: streaming murmur3 x86 32-bit hash with apb seed
// register; instantiates mm3_ctrl and mm3_dpath, uses mm3_pkg
`timescale 1ns / 1ps
//
// Input stream (s_*): one beat per little-endian message word. tdata
// carries data_word in bits 31:0 and byte_count in 34:32; tlast marks the
// final word, whose byte_count (0 to 4, larger values count as 4) gives
// its valid low bytes. Non-last words always count as four bytes.
// Output stream (m_*): one beat per message, the finalized hash in tdata.
// APB: register 0 at address 0 is the seed, loaded at each message start.
// Sequencing: every beat runs through one shared sequencer: the load step,
// two registered multiplies and the accumulate step. A last word adds two
// finalize multiplies and the output load, which waits while the output
// register holds a result that is not yet taken. No new beat is accepted
// until the sequence for the current beat ends.
// Reset clears the seed to zero and closes any open message.
// A stalled receiver holds the result in the output register; the next
// message is accepted meanwhile and only its own result waits for space.
//

module murmur3_32_hash_top import mm3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // data_word[31:0], byte_count[34:32], zero pad
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // hash[31:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] seed;
  logic        sel_seed;

  assign pready   = 1'b1;
  assign sel_seed = (paddr[2] == REG_SEED[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 32'd0;
    end else if (psel && penable && pwrite && pready && sel_seed) begin
      seed <= pwdata;
    end
  end

  assign prdata = sel_seed ? seed : 32'd0;

  mm3_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mm3_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .seed       (seed),
    .data_word  (s_tdata[31:0]),
    .byte_count (s_tdata[34:32]),
    .last       (s_tlast),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .hash       (m_tdata)
  );

`ifndef SYNTH
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("beat accepted while previous beat still in work");

  a_word_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tlast |-> ##4 s_tready)
    else $error("non-last word did not finish in four cycles");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !m_tvalid || m_tready)
    else $error("result loaded over a waiting result");
`endif

endmodule

FILE: hw/rtl/mm3_ctrl.sv
// mm3_ctrl: sequencer for the murmur3 engine, steps one beat through
// premix, accumulate and, for a last word, finalize; uses mm3_pkg
`timescale 1ns / 1ps

module mm3_ctrl import mm3_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_MUL2 = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_FIN1 = 3'd4;
  localparam logic [2:0] ST_FIN2 = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = sts.last ? ST_FIN1 : ST_IDLE;
      end
      ST_FIN1: begin
        cmd.fin1   = 1'b1;
        state_next = ST_FIN2;
      end
      ST_FIN2: begin
        cmd.fin2   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/mm3_dpath.sv
// mm3_dpath: word register, registered multipliers, accumulator, length
// counter and output register of the murmur3 engine; uses mm3_pkg
`timescale 1ns / 1ps

module mm3_dpath import mm3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [31:0] seed,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash
);

  logic [31:0] k;
  logic [31:0] h;
  logic [31:0] len;
  logic [1:0]  mode;
  logic        last_q;
  logic        msg_open;

  logic [2:0]  cnt_sat;
  logic [31:0] word_masked;
  logic [1:0]  mode_in;
  logic [31:0] len_add;
  logic [31:0] k_rot;
  logic [31:0] hk_rot;
  logic [31:0] h_full;
  logic [31:0] h_len;
  logic [31:0] h_f1;
  logic [31:0] h_f2;

  always_comb begin
    cnt_sat = (byte_count > 3'd4) ? 3'd4 : byte_count;
    case (cnt_sat)
      3'd1:    word_masked = {24'h0, data_word[7:0]};
      3'd2:    word_masked = {16'h0, data_word[15:0]};
      3'd3:    word_masked = {8'h0, data_word[23:0]};
      default: word_masked = data_word;
    endcase
    if (!last || cnt_sat == 3'd4) begin
      mode_in = MODE_FULL;
    end else if (cnt_sat == 3'd0) begin
      mode_in = MODE_NONE;
    end else begin
      mode_in = MODE_TAIL;
    end
    len_add = last ? {29'h0, cnt_sat} : 32'd4;
  end

  assign k_rot  = {k[16:0], k[31:17]};
  assign hk_rot = {h[18:0] ^ k[18:0], h[31:19] ^ k[31:19]};
  assign h_full = hk_rot + {hk_rot[29:0], 2'b00} + MM_N;
  assign h_len  = h ^ len;
  assign h_f1   = h_len ^ {16'h0, h_len[31:16]};
  assign h_f2   = h ^ {13'h0, h[31:13]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k      <= last ? word_masked : data_word;
      mode   <= mode_in;
      last_q <= last;
      len    <= (msg_open ? len : 32'd0) + len_add;
      if (!msg_open) begin
        h <= seed;
      end
    end
    if (cmd.mul1) begin
      k <= k * MM_C1;
    end
    if (cmd.mul2) begin
      k <= k_rot * MM_C2;
    end
    if (cmd.acc) begin
      case (mode)
        MODE_FULL: h <= h_full;
        MODE_TAIL: h <= h ^ k;
        default:   h <= h;
      endcase
    end
    if (cmd.fin1) begin
      h <= h_f1 * MM_F1;
    end
    if (cmd.fin2) begin
      h <= h_f2 * MM_F2;
    end
    if (cmd.emit) begin
      hash <= h ^ {16'h0, h[31:16]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_open  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.acc) begin
        msg_open <= !last_q;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.last     = last_q;
  assign sts.out_busy = out_valid && !out_ready;

endmodule
